// File: rtl/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL converter.
package rgbhsl_pkg;

  // One input pixel; the first member sits in the most significant bits.
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  // One converted pixel.
  typedef struct packed {
    logic [14:0] hue_out;
    logic [16:0] saturation_out;
    logic [8:0]  lightness_twice;
  } hsl_t;

  // Hue sector, chosen by the largest channel; red with a negative
  // difference sits in the last sextant before the wrap.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE,
    SEC_RED_WRAP
  } sector_t;

  // Per-pixel flags and values that travel alongside the dividers.
  typedef struct packed {
    sector_t    sector;
    logic [8:0] sum;
    logic       grey;
    logic       sat_zero;
  } side_t;

  // Long division: dividend width, divisor width and quotient bits per stage.
  localparam int DIV_NUM_W  = 24;
  localparam int DIV_DEN_W  = 8;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;

  localparam logic [14:0] HUE_SECT = 15'd3840;   // 60 degrees in 1/64 degree
  localparam logic [14:0] HUE_FULL = 15'd23040;  // 360 degrees in 1/64 degree

  // Hue offset of a sector in 1/64 degree, before the one-sector correction.
  function automatic logic [14:0] sector_base(sector_t sec);
    logic [14:0] base;
    case (sec)
      SEC_RED:      base = 15'd0;
      SEC_GREEN:    base = 15'd7680;
      SEC_BLUE:     base = 15'd15360;
      SEC_RED_WRAP: base = 15'd23040;
      default:      base = 15'd0;
    endcase
    return base;
  endfunction

endpackage

// File: rtl/rgbhsl_div.sv
// Pipelined restoring divider with per-stage advance enables.
module rgbhsl_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8,
  parameter int STEPS = 4
) (
  input  logic                         clk,
  input  logic [NUM_W/STEPS-1:0]       adv,
  input  logic [NUM_W-1:0]             num_i,
  input  logic [DEN_W-1:0]             den_i,
  output logic [NUM_W-1:0]             quo_o,
  output logic [DEN_W-1:0]             rem_o,
  output logic [DEN_W-1:0]             den_o
);

  localparam int STAGES = NUM_W / STEPS;

  // Dividend bits shift out at the top while quotient bits shift in below.
  logic [NUM_W-1:0] nq_r   [STAGES];
  logic [DEN_W-1:0] rem_r  [STAGES];
  logic [DEN_W-1:0] den_r  [STAGES];
  logic [NUM_W-1:0] nq_nxt [STAGES];
  logic [DEN_W-1:0] rem_nxt[STAGES];
  logic [DEN_W-1:0] den_nxt[STAGES];

  always_comb begin
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [DEN_W:0]   trial;
    nq    = '0;
    rem   = '0;
    den   = '0;
    trial = '0;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        nq  = num_i;
        rem = '0;
        den = den_i;
      end else begin
        nq  = nq_r[k-1];
        rem = rem_r[k-1];
        den = den_r[k-1];
      end
      for (int s = 0; s < STEPS; s++) begin
        trial = {rem, nq[NUM_W-1]};
        nq    = {nq[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem   = DEN_W'(trial - {1'b0, den});
          nq[0] = 1'b1;
        end else begin
          rem = trial[DEN_W-1:0];
        end
      end
      nq_nxt[k]  = nq;
      rem_nxt[k] = rem;
      den_nxt[k] = den;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (adv[k]) begin
        nq_r[k]  <= nq_nxt[k];
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_nxt[k];
      end
    end
  end

  assign quo_o = nq_r[STAGES-1];
  assign rem_o = rem_r[STAGES-1];
  assign den_o = den_r[STAGES-1];

endmodule

// File: rtl/rgb_to_hsl_converter.sv
// Top level of the pipelined RGB to HSL pixel converter.
//
// Usage: pixels enter on the in_ channel (in_valid, in_ready, in_data) and
// leave on the out_ channel (out_valid, out_ready, out_data). A transaction
// happens on a channel at each rising clock edge where its valid and ready
// are both high. Every input transaction produces exactly one output
// transaction, in order.
//
// Throughput is one pixel per clock while out_ready stays high. The pipeline
// has eight register stages. The depth comes from the two 24-step long
// divisions (hue and saturation, side by side), which retire four quotient
// bits per stage over six stages, plus one stage for min/max and one for
// rounding.
//
// Reset (rst_n low at a clock edge) clears every stage valid bit, so the
// pipeline comes out empty; payload registers are not reset.
// When the receiver holds out_ready low, the stalled result stays on
// out_data and the stages behind it keep filling any empty slots; in_ready
// drops only once every stage holds a pixel. Nothing is dropped or repeated.
module rgb_to_hsl_converter
  import rgbhsl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output hsl_t   out_data
);

  // Stage 0 is the min/max stage, stages 1..DIV_STAGES are the divider,
  // and the last stage is the output register.
  localparam int NSTG = DIV_STAGES + 2;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  // A stage may load when it is empty or when its content moves on.
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 0: max, min, chroma, sector and the shifted hue difference.
  // The difference plus chroma (0..2C) keeps the hue dividend non-negative;
  // the extra sector of 3840 is taken off again after rounding.
  logic [7:0] mx;
  logic [7:0] mn;
  logic [7:0] chroma;
  logic [8:0] sum;
  logic [7:0] denom;
  logic [9:0] u_ext;
  side_t      side_nxt;

  always_comb begin
    mx = in_data.red_in;
    if (in_data.green_in > mx) mx = in_data.green_in;
    if (in_data.blue_in > mx)  mx = in_data.blue_in;
    mn = in_data.red_in;
    if (in_data.green_in < mn) mn = in_data.green_in;
    if (in_data.blue_in < mn)  mn = in_data.blue_in;

    chroma = mx - mn;
    sum    = {1'b0, mx} + {1'b0, mn};
    if (sum <= 9'd255) begin
      denom = sum[7:0];
    end else begin
      denom = 8'(9'd510 - sum);
    end

    // Ties on the maximum go to red first, then green.
    if (mx == in_data.red_in) begin
      side_nxt.sector = (in_data.green_in >= in_data.blue_in) ? SEC_RED : SEC_RED_WRAP;
      u_ext = {2'b00, in_data.green_in} - {2'b00, in_data.blue_in} + {2'b00, chroma};
    end else if (mx == in_data.green_in) begin
      side_nxt.sector = SEC_GREEN;
      u_ext = {2'b00, in_data.blue_in} - {2'b00, in_data.red_in} + {2'b00, chroma};
    end else begin
      side_nxt.sector = SEC_BLUE;
      u_ext = {2'b00, in_data.red_in} - {2'b00, in_data.green_in} + {2'b00, chroma};
    end

    side_nxt.sum      = sum;
    side_nxt.grey     = (chroma == 8'd0);
    side_nxt.sat_zero = (mx == 8'd0) || (mn == 8'd255);
  end

  side_t      prep_side_r;
  logic [8:0] prep_u_r;
  logic [7:0] prep_c_r;
  logic [7:0] prep_d_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prep_side_r <= side_nxt;
      prep_u_r    <= u_ext[8:0];
      prep_c_r    <= chroma;
      prep_d_r    <= denom;
    end
  end

  // Dividends: (diff + C) * 3840 for hue, C * 65536 for saturation.
  logic [20:0]          hue_prod;
  logic [DIV_NUM_W-1:0] hue_num;
  logic [DIV_NUM_W-1:0] sat_num;

  assign hue_prod = {prep_u_r, 12'b0} - {4'b0, prep_u_r, 8'b0};
  assign hue_num  = {{(DIV_NUM_W - 21){1'b0}}, hue_prod};
  assign sat_num  = {prep_c_r, 16'b0};

  logic [DIV_NUM_W-1:0] hue_q;
  logic [DIV_DEN_W-1:0] hue_rem;
  logic [DIV_DEN_W-1:0] hue_den;
  logic [DIV_NUM_W-1:0] sat_q;
  logic [DIV_DEN_W-1:0] sat_rem;
  logic [DIV_DEN_W-1:0] sat_den;

  rgbhsl_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .STEPS (DIV_STEPS)
  ) u_hue_div (
    .clk   (clk),
    .adv   (adv[DIV_STAGES:1]),
    .num_i (hue_num),
    .den_i (prep_c_r),
    .quo_o (hue_q),
    .rem_o (hue_rem),
    .den_o (hue_den)
  );

  rgbhsl_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .STEPS (DIV_STEPS)
  ) u_sat_div (
    .clk   (clk),
    .adv   (adv[DIV_STAGES:1]),
    .num_i (sat_num),
    .den_i (prep_d_r),
    .quo_o (sat_q),
    .rem_o (sat_rem),
    .den_o (sat_den)
  );

  // The side information walks beside the divider stages.
  side_t side_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      side_r[0] <= prep_side_r;
    end
    for (int j = 1; j < DIV_STAGES; j++) begin
      if (adv[j+1]) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // Output stage: round to nearest with ties up (remainder at least half the
  // divisor), add the sector offset, wrap a full circle to zero and apply
  // the grey, black and white overrides.
  side_t       side_last;
  logic        hue_up;
  logic        sat_up;
  logic [14:0] hue_rnd;
  logic [15:0] hue_sum;
  logic [16:0] sat_rnd;
  hsl_t        out_nxt;

  always_comb begin
    side_last = side_r[DIV_STAGES-1];
    hue_up    = ({hue_rem, 1'b0} >= {1'b0, hue_den});
    sat_up    = ({sat_rem, 1'b0} >= {1'b0, sat_den});
    hue_rnd   = hue_q[14:0] + {14'b0, hue_up};
    hue_sum   = {1'b0, hue_rnd} + {1'b0, sector_base(side_last.sector)}
              - {1'b0, HUE_SECT};
    sat_rnd   = sat_q[16:0] + {16'b0, sat_up};

    if (side_last.grey || (hue_sum[14:0] == HUE_FULL)) begin
      out_nxt.hue_out = '0;
    end else begin
      out_nxt.hue_out = hue_sum[14:0];
    end
    out_nxt.saturation_out  = side_last.sat_zero ? 17'd0 : sat_rnd;
    out_nxt.lightness_twice = side_last.sum;
  end

  hsl_t out_data_r;

  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

  // The wrap logic never lets a full circle through.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hue_out < HUE_FULL))
    else $error("hue_out reached a full circle");

  // Saturation never exceeds 1.0 in Q1.16.
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.saturation_out <= 17'd65536))
    else $error("saturation_out above one");

  // A black pixel is grey and unsaturated.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.lightness_twice == 9'd0)) |->
      ((out_data.hue_out == 15'd0) && (out_data.saturation_out == 17'd0)))
    else $error("black pixel with nonzero hue or saturation");

  // Input backpressure only appears once every stage is occupied.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("in_ready low while a pipeline slot is empty");

endmodule

// File: sim/hsl_checker.sv
// Checker that predicts each converted pixel and compares it with the block's output.
module hsl_checker
  import rgbhsl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_ready,
  input  pixel_t in_data,
  input  logic   out_valid,
  input  logic   out_ready,
  input  hsl_t   out_data,
  output int     fail_count,
  output int     pending_count,
  output int     checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SIXTY_DEG = 3840;   // 60 degrees in 1/64 degree
  localparam longint FULL_TURN = 23040;  // 360 degrees in 1/64 degree
  localparam longint ONE_Q16   = 65536;  // 1.0 in Q1.16
  localparam int     SHOW_MAX  = 10;

  hsl_t hsl_expected_q[$];
  int   shown;

  // Exact rational hue and saturation, rounded half up.
  function automatic hsl_t convert_pixel(pixel_t px);
    int      r, g, b, mx, mn, chroma, total, diff, den;
    longint  num, q;
    sector_t sec;
    hsl_t    res;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    mx = (r > g) ? r : g;
    mx = (b > mx) ? b : mx;
    mn = (r < g) ? r : g;
    mn = (b < mn) ? b : mn;
    chroma = mx - mn;
    total = mx + mn;
    res = '0;
    res.lightness_twice = total[8:0];
    if (chroma != 0) begin
      // Ties for the maximum go to red first, then green.
      if (mx == r) begin
        sec = SEC_RED;
        diff = g - b;
      end else if (mx == g) begin
        sec = SEC_GREEN;
        diff = b - r;
      end else begin
        sec = SEC_BLUE;
        diff = r - g;
      end
      num = SIXTY_DEG * (2 * int'(sec) * chroma + diff);
      if (num < 0) begin
        num += FULL_TURN * chroma;
      end
      q = (2 * num + chroma) / (2 * chroma);
      if (q >= FULL_TURN) begin
        q = 0;
      end
      res.hue_out = q[14:0];
    end
    // Black and white have no saturation.
    if (mx != 0 && mn != 255) begin
      den = (total < 510 - total) ? total : 510 - total;
      if (den > 0) begin
        q = (2 * ONE_Q16 * chroma + den) / (2 * den);
        res.saturation_out = q[16:0];
      end
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
    checked_count = 0;
    shown = 0;
  end

  always @(posedge clk) begin : watch
    hsl_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        hsl_expected_q.push_back(convert_pixel(in_data));
      end
      if (out_valid && out_ready) begin
        if (hsl_expected_q.size() == 0) begin
          fail_count++;
          if (shown < SHOW_MAX) begin
            shown++;
            $display("unexpected result: hue %0d sat %0d light %0d", out_data.hue_out,
                     out_data.saturation_out, out_data.lightness_twice);
          end
        end else begin
          want = hsl_expected_q.pop_front();
          checked_count++;
          if (want.hue_out != out_data.hue_out ||
              want.saturation_out != out_data.saturation_out ||
              want.lightness_twice != out_data.lightness_twice) begin
            fail_count++;
            if (shown < SHOW_MAX) begin
              shown++;
              $display("result %0d wrong: hue %0d/%0d sat %0d/%0d light %0d/%0d (exp/got)",
                       checked_count, want.hue_out, out_data.hue_out,
                       want.saturation_out, out_data.saturation_out,
                       want.lightness_twice, out_data.lightness_twice);
            end
          end
        end
      end
      pending_count = hsl_expected_q.size();
    end
  end

endmodule

// File: sim/tb_rgb_to_hsl_converter.sv
// Testbench top for the RGB to HSL converter: stimulus, flow control and verdict.
module tb_rgb_to_hsl_converter import rgbhsl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // This limit is far beyond the slowest legal run.
  localparam int WATCHDOG_CYCLES = 200000;
  // Length of the deliberate receiver stall, well past the pipeline depth.
  localparam int HOLD_CYCLES = 200;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int TAIL_CYCLES = 20;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  pixel_t in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  hsl_t   out_data;

  int fail_count;
  int pending_count;
  int checked_count;

  // Percentages of cycles in which each side stays idle.
  int send_idle_pct = 26;
  int recv_idle_pct = 53;

  // The stimulus bumps hold_seq to request a long receiver stall; the receiver
  // process notices the change and counts the stall down on its own.
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int pixels_sent = 0;

  // Corner pixels as 0xRRGGBB: black, white, greys, primaries, ties for the
  // maximum, red with a negative difference (the wrapping sextant), and the
  // darkest and lightest non-grey colors where saturation reaches one.
  logic [23:0] corner_rgb [24] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFEFEFE,
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF,
    24'hFF00FF, 24'hFF0001, 24'hFF0100, 24'h000100, 24'h000001,
    24'hFFFEFF, 24'hFEFFFF, 24'h7F8000, 24'h80017F, 24'hAA55AA,
    24'h55AA55, 24'h01FF00, 24'h7F7F80, 24'h80007F
  };

  rgb_to_hsl_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hsl_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver side: out_ready changes only on the falling edge, either from the
  // random idle pattern or held low for a whole requested stall.
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Channel values that matter most: the ends of the range and their neighbors.
  function automatic logic [7:0] pick_extreme();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random pixel with a bias toward greys, ties for the maximum and extremes,
  // so that every branch of the hue and saturation math is hit often.
  function automatic pixel_t rand_pixel();
    pixel_t px;
    int     kind;
    kind = $urandom_range(99);
    px.red_in = 8'($urandom_range(255));
    px.green_in = 8'($urandom_range(255));
    px.blue_in = 8'($urandom_range(255));
    if (kind < 15) begin
      px.green_in = px.red_in;
      px.blue_in = px.red_in;
    end else if (kind < 30) begin
      case ($urandom_range(2))
        0: px.green_in = px.red_in;
        1: px.blue_in = px.green_in;
        default: px.blue_in = px.red_in;
      endcase
    end else if (kind < 45) begin
      px.red_in = pick_extreme();
      px.green_in = pick_extreme();
      px.blue_in = pick_extreme();
    end
    return px;
  endfunction

  // Offers one pixel: optional idle cycles first, then valid stays high with a
  // steady payload until the transaction completes at a rising edge. Each
  // falling edge assigns in_valid once, so back-to-back pixels keep it high.
  task automatic send_pixel(pixel_t px);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_data = rand_pixel();
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = px;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pixels_sent++;
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      send_pixel(rand_pixel());
    end
  endtask

  // Stops offering pixels and waits until every expected result has arrived.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) begin
      @(negedge clk);
    end
  endtask

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    repeat (WATCHDOG_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles", WATCHDOG_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    // Reset is held from the start and released on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // First mix: sender idles lightly, receiver heavily.
    foreach (corner_rgb[i]) begin
      send_pixel(pixel_t'(corner_rgb[i]));
    end
    send_random(550);

    // Backpressure: with the pipeline empty, the receiver stalls for a long
    // stretch while the sender offers pixels without gaps. The pipeline fills,
    // in_ready falls, and the sender waits until the stall ends.
    wait_for_drain();
    send_idle_pct = 0;
    hold_seq++;
    send_random(40);
    wait_for_drain();

    // Second mix: the other way round.
    send_idle_pct = 53;
    recv_idle_pct = 26;
    send_random(600);

    // Third mix: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(640);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixels (corners, biased random, a long output stall, three idle mixes);",
             pixels_sent);
    $display("checked %0d results, %0d failures, %0d still expected.", checked_count,
             fail_count, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
